// ----- sv/dcf_pkg.sv -----
// Shared constants, codes and the job record for the display command framer.
`timescale 1ns / 1ps

package dcf_pkg;

  localparam int HISTORY_DEPTH = 128;
  localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
  localparam int HCNT_W        = $clog2(HISTORY_DEPTH + 1);
  localparam int MAX_DIGITS    = 3;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_PAY   = 2'd1;
  localparam logic [1:0] OP_REPLY = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  localparam logic [1:0] KIND_TX  = 2'd0;
  localparam logic [1:0] KIND_OK  = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  localparam logic [1:0] JOB_HDR = 2'd0;
  localparam logic [1:0] JOB_PAY = 2'd1;
  localparam logic [1:0] JOB_RPT = 2'd2;

  localparam logic [7:0] SOF_BYTE = 8'hA5;
  localparam logic [7:0] TRL0     = 8'hCC;
  localparam logic [7:0] TRL1     = 8'h33;
  localparam logic [7:0] TRL2     = 8'hC3;
  localparam logic [7:0] TRL3     = 8'h3C;
  localparam logic [15:0] FRAME_OVERHEAD = 16'd9;

  localparam logic [7:0] CHAR_OK   = 8'h4F;
  localparam logic [7:0] CHAR_ERR  = 8'h45;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

  typedef struct packed {
    logic [1:0]  jtype;
    logic [7:0]  byte_val;
    logic [15:0] flen;
    logic        tail;
    logic [7:0]  parity;
    logic [1:0]  rkind;
    logic        empty;
    logic [1:0]  cnt;
    logic [3:0]  d0;
    logic [3:0]  d1;
    logic [3:0]  d2;
    logic        last;
  } job_t;

endpackage

// ----- sv/dcf_front.sv -----
// Front end: accepts items, keeps frame, history and reply state, issues jobs.
`timescale 1ns / 1ps

module dcf_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [7:0]         in_byte,
  input  logic [15:0]        in_plen,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               q_full,
  output logic               q_push,
  output dcf_pkg::job_t      q_job
);

  logic [7:0]                 hist_mem [dcf_pkg::HISTORY_DEPTH];
  logic [7:0]                 rdata_r;

  logic [dcf_pkg::SLOT_W-1:0] oldest_r, oldest_nxt;
  logic [dcf_pkg::SLOT_W-1:0] free_r, free_nxt;
  logic [dcf_pkg::HCNT_W-1:0] hcnt_r, hcnt_nxt;
  logic [15:0]                payrem_r, payrem_nxt;
  logic [7:0]                 parity_r, parity_nxt;
  logic [3:0]                 dig_r [3];
  logic [3:0]                 dig_nxt [3];
  logic [1:0]                 ccnt_r, ccnt_nxt;
  logic                       trun_r, trun_nxt;
  logic [15:0]                tel_r, tel_nxt;
  logic [15:0]                tmo_r;
  logic                       pend_ok_r, pend_ok_nxt;
  logic                       s1_valid_r, s1_valid_nxt;
  dcf_pkg::job_t              s1_job_r, s1_job_nxt;

  logic                       s1_ready;
  logic                       take;
  logic                       wr_en;
  logic [15:0]                tel_inc;
  logic [15:0]                tlim;
  logic [15:0]                flen;
  logic [3:0]                 digit_val;

  function automatic logic [dcf_pkg::SLOT_W-1:0] slot_next(
    input logic [dcf_pkg::SLOT_W-1:0] s);
    if (s == dcf_pkg::SLOT_W'(dcf_pkg::HISTORY_DEPTH - 1)) begin
      return '0;
    end
    return s + 1'b1;
  endfunction

  assign s1_ready = !s1_valid_r || !q_full;
  assign in_ready = s1_ready && !pend_ok_r;
  assign take     = in_valid && in_ready;
  assign q_push   = s1_valid_r && !q_full;

  assign tel_inc   = (tel_r == 16'hFFFF) ? tel_r : tel_r + 16'd1;
  assign tlim      = (tmo_r == 16'd0) ? 16'd1 : tmo_r;
  assign flen      = in_plen + dcf_pkg::FRAME_OVERHEAD;
  assign digit_val = in_byte[3:0] - dcf_pkg::CHAR_ZERO[3:0];

  always_comb begin
    q_job = s1_job_r;
    if (s1_job_r.jtype == dcf_pkg::JOB_RPT) begin
      q_job.byte_val = s1_job_r.empty ? 8'd0 : rdata_r;
    end
  end

  always_comb begin
    oldest_nxt   = oldest_r;
    free_nxt     = free_r;
    hcnt_nxt     = hcnt_r;
    payrem_nxt   = payrem_r;
    parity_nxt   = parity_r;
    dig_nxt      = dig_r;
    ccnt_nxt     = ccnt_r;
    trun_nxt     = trun_r;
    tel_nxt      = tel_r;
    pend_ok_nxt  = pend_ok_r;
    s1_valid_nxt = s1_valid_r && q_full;
    s1_job_nxt   = s1_job_r;
    wr_en        = 1'b0;

    if (s1_ready) begin
      s1_job_nxt       = '0;
      s1_job_nxt.jtype = dcf_pkg::JOB_RPT;
      s1_job_nxt.empty = (hcnt_r == '0);
      s1_job_nxt.last  = 1'b1;

      if (pend_ok_r) begin
        pend_ok_nxt      = 1'b0;
        s1_valid_nxt     = 1'b1;
        s1_job_nxt.rkind = dcf_pkg::KIND_OK;
      end else if (take) begin
        unique case (in_op)
          dcf_pkg::OP_FRAME: begin
            wr_en    = 1'b1;
            free_nxt = slot_next(free_r);
            if (hcnt_r == dcf_pkg::HCNT_W'(dcf_pkg::HISTORY_DEPTH)) begin
              oldest_nxt = slot_next(oldest_r);
            end else begin
              hcnt_nxt = hcnt_r + 1'b1;
            end
            parity_nxt          = dcf_pkg::SOF_BYTE ^ flen[15:8] ^ flen[7:0] ^ in_byte;
            payrem_nxt          = in_plen;
            s1_valid_nxt        = 1'b1;
            s1_job_nxt.jtype    = dcf_pkg::JOB_HDR;
            s1_job_nxt.empty    = 1'b0;
            s1_job_nxt.byte_val = in_byte;
            s1_job_nxt.flen     = flen;
            s1_job_nxt.tail     = (in_plen == 16'd0);
            s1_job_nxt.parity   = parity_nxt;
          end
          dcf_pkg::OP_PAY: begin
            if (payrem_r != 16'd0) begin
              parity_nxt          = parity_r ^ in_byte;
              payrem_nxt          = payrem_r - 16'd1;
              s1_valid_nxt        = 1'b1;
              s1_job_nxt.jtype    = dcf_pkg::JOB_PAY;
              s1_job_nxt.empty    = 1'b0;
              s1_job_nxt.byte_val = in_byte;
              s1_job_nxt.tail     = (payrem_r == 16'd1);
              s1_job_nxt.parity   = parity_nxt;
            end
          end
          dcf_pkg::OP_REPLY: begin
            if (in_byte == dcf_pkg::CHAR_OK || in_byte == dcf_pkg::CHAR_ERR) begin
              trun_nxt = 1'b0;
              if (ccnt_r != 2'd0) begin
                s1_valid_nxt     = 1'b1;
                s1_job_nxt.rkind = dcf_pkg::KIND_ERR;
                s1_job_nxt.cnt   = ccnt_r;
                s1_job_nxt.d0    = dig_r[0];
                s1_job_nxt.d1    = dig_r[1];
                s1_job_nxt.d2    = dig_r[2];
                s1_job_nxt.last  = (in_byte == dcf_pkg::CHAR_ERR);
                ccnt_nxt         = 2'd0;
                dig_nxt          = '{default: 4'd0};
                pend_ok_nxt      = (in_byte == dcf_pkg::CHAR_OK);
              end else if (in_byte == dcf_pkg::CHAR_OK) begin
                s1_valid_nxt     = 1'b1;
                s1_job_nxt.rkind = dcf_pkg::KIND_OK;
              end
            end else if (in_byte >= dcf_pkg::CHAR_ZERO && in_byte <= dcf_pkg::CHAR_NINE) begin
              if (ccnt_r < 2'(dcf_pkg::MAX_DIGITS)) begin
                dig_nxt[ccnt_r] = digit_val;
                ccnt_nxt        = ccnt_r + 2'd1;
              end
              trun_nxt = 1'b1;
              tel_nxt  = 16'd0;
            end
          end
          dcf_pkg::OP_TICK: begin
            if (trun_r) begin
              if (tel_inc >= tlim) begin
                trun_nxt         = 1'b0;
                tel_nxt          = 16'd0;
                s1_valid_nxt     = 1'b1;
                s1_job_nxt.rkind = dcf_pkg::KIND_ERR;
                s1_job_nxt.cnt   = ccnt_r;
                s1_job_nxt.d0    = dig_r[0];
                s1_job_nxt.d1    = dig_r[1];
                s1_job_nxt.d2    = dig_r[2];
                ccnt_nxt         = 2'd0;
                dig_nxt          = '{default: 4'd0};
              end else begin
                tel_nxt = tel_inc;
              end
            end
          end
          default: begin
          end
        endcase
      end

      if (s1_valid_nxt && s1_job_nxt.jtype == dcf_pkg::JOB_RPT && hcnt_r != '0) begin
        oldest_nxt = slot_next(oldest_r);
        hcnt_nxt   = hcnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_mem[free_r] <= in_byte;
    end
    if (s1_ready) begin
      rdata_r <= hist_mem[oldest_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r   <= '0;
      free_r     <= '0;
      hcnt_r     <= '0;
      payrem_r   <= '0;
      parity_r   <= '0;
      dig_r      <= '{default: 4'd0};
      ccnt_r     <= '0;
      trun_r     <= 1'b0;
      tel_r      <= '0;
      tmo_r      <= dcf_pkg::TIMEOUT_RESET;
      pend_ok_r  <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      oldest_r   <= oldest_nxt;
      free_r     <= free_nxt;
      hcnt_r     <= hcnt_nxt;
      payrem_r   <= payrem_nxt;
      parity_r   <= parity_nxt;
      dig_r      <= dig_nxt;
      ccnt_r     <= ccnt_nxt;
      trun_r     <= trun_nxt;
      tel_r      <= tel_nxt;
      pend_ok_r  <= pend_ok_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (cfg_wr_en) begin
        tmo_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_job_r <= s1_job_nxt;
  end

endmodule

// ----- sv/dcf_queue.sv -----
// Short job queue between the front end and the result sequencer.
`timescale 1ns / 1ps

module dcf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dcf_pkg::job_t push_job,
  input  logic          pop,
  output dcf_pkg::job_t head_job,
  output logic          full,
  output logic          empty
);

  dcf_pkg::job_t            slot_r [dcf_pkg::Q_DEPTH];
  logic [dcf_pkg::Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [dcf_pkg::Q_CW-1:0] cnt_r;

  assign full     = (cnt_r == dcf_pkg::Q_CW'(dcf_pkg::Q_DEPTH));
  assign empty    = (cnt_r == '0);
  assign head_job = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- sv/dcf_back.sv -----
// Result sequencer: expands queued jobs into result items behind an output register.
`timescale 1ns / 1ps

module dcf_back (
  input  logic          clk,
  input  logic          rst_n,
  input  dcf_pkg::job_t head_job,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_kind,
  output logic          out_last,
  output logic [7:0]    out_tx_byte,
  output logic [7:0]    out_cmd,
  output logic          out_empty,
  output logic [1:0]    out_cnt,
  output logic [3:0]    out_d0,
  output logic [3:0]    out_d1,
  output logic [3:0]    out_d2
);

  logic [3:0] idx_r, idx_nxt;
  logic       ov_r;
  logic [3:0] pos;
  logic       step;
  logic       job_end;
  logic [7:0] sel_byte;

  assign step  = !q_empty && (!ov_r || out_ready);
  assign pos   = (head_job.jtype == dcf_pkg::JOB_PAY) ? idx_r + 4'd3 : idx_r;
  assign job_end = (head_job.jtype == dcf_pkg::JOB_RPT) ||
                   (pos == (head_job.tail ? 4'd8 : 4'd3));
  assign q_pop = step && job_end;
  assign idx_nxt = job_end ? 4'd0 : idx_r + 4'd1;
  assign out_valid = ov_r;

  always_comb begin
    unique case (pos)
      4'd0:    sel_byte = dcf_pkg::SOF_BYTE;
      4'd1:    sel_byte = head_job.flen[15:8];
      4'd2:    sel_byte = head_job.flen[7:0];
      4'd3:    sel_byte = head_job.byte_val;
      4'd4:    sel_byte = dcf_pkg::TRL0;
      4'd5:    sel_byte = dcf_pkg::TRL1;
      4'd6:    sel_byte = dcf_pkg::TRL2;
      4'd7:    sel_byte = dcf_pkg::TRL3;
      default: sel_byte = head_job.parity;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      if (step) begin
        idx_r <= idx_nxt;
        ov_r  <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (head_job.jtype == dcf_pkg::JOB_RPT) begin
        out_kind    <= head_job.rkind;
        out_last    <= head_job.last;
        out_tx_byte <= 8'd0;
        out_cmd     <= head_job.byte_val;
        out_empty   <= head_job.empty;
        out_cnt     <= head_job.cnt;
        out_d0      <= head_job.d0;
        out_d1      <= head_job.d1;
        out_d2      <= head_job.d2;
      end else begin
        out_kind    <= dcf_pkg::KIND_TX;
        out_last    <= job_end;
        out_tx_byte <= sel_byte;
        out_cmd     <= 8'd0;
        out_empty   <= 1'b0;
        out_cnt     <= 2'd0;
        out_d0      <= 4'd0;
        out_d1      <= 4'd0;
        out_d2      <= 4'd0;
      end
    end
  end

endmodule

// ----- sv/display_command_framer_and_reply_tracker.sv -----
// Top level of the display command framer and reply tracker.
// Jobs pass the issue register, the job queue and the output register. Items are accepted
// one per cycle; an 'O' reply that also reports an error holds the input until its OK
// report is issued, and the input stalls while the issue register and the four-job queue
// are full. Results leave at one per cycle while out_tready is high, four or nine for a
// frame start. Reset clears all control state and sets the reply timeout to 1000 ticks.
`timescale 1ns / 1ps

module display_command_framer_and_reply_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // byte_value [7:0], payload_length [23:8]
  input  logic [1:0]  in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // tx_byte, report_command, history_was_empty,
                                  // digit_count, first_, second_, third_digit, zero pad
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  dcf_pkg::job_t push_job;
  dcf_pkg::job_t head_job;
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  logic [7:0]    tx_byte;
  logic [7:0]    report_command;
  logic          history_was_empty;
  logic [1:0]    digit_count;
  logic [3:0]    first_digit;
  logic [3:0]    second_digit;
  logic [3:0]    third_digit;

  dcf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_op       (in_tuser),
    .in_byte     (in_tdata[7:0]),
    .in_plen     (in_tdata[23:8]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (push_job)
  );

  dcf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  dcf_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_job    (head_job),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_kind    (out_tuser),
    .out_last    (out_tlast),
    .out_tx_byte (tx_byte),
    .out_cmd     (report_command),
    .out_empty   (history_was_empty),
    .out_cnt     (digit_count),
    .out_d0      (first_digit),
    .out_d1      (second_digit),
    .out_d2      (third_digit)
  );

  assign out_tdata = {1'b0, third_digit, second_digit, first_digit, digit_count,
                      history_was_empty, report_command, tx_byte};

endmodule
